>>> rtl/core/vwib_pkg.sv
package vwib_pkg;

    // coordinate and vertex layout
    localparam int COORD_W = 32;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
        coord_t nrm_x;
        coord_t nrm_y;
        coord_t nrm_z;
        coord_t tex_u;
        coord_t tex_v;
    } vertex_t;

    // result field widths
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    // position and normal difference magnitudes at or above 2^24 square to 2^48 or more and never match
    localparam int SQ_IN_W  = 24;
    localparam int SQ_W     = 2 * SQ_IN_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int TOL_W    = 32;
    localparam int FRAC_W   = 16;

    // register file
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_POS_TOL = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_NRM_TOL = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TEX_TOL = 2'd2;

    localparam logic [TOL_W-1:0] TOL_RESET = 32'd66;

    // exact absolute difference of two signed coordinates
    function automatic logic [COORD_W:0] abs_diff(coord_t a, coord_t b);
        logic [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[COORD_W] ? (~d + 1'b1) : d;
    endfunction

endpackage

>>> rtl/core/vwib_ram.sv
module vwib_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/vertex_weld_index_builder.sv
// vertex weld index builder
// request channel: a vertex (first_of_mesh, position, normal, texcoord) is taken
// at a rising edge with start high and busy low; busy stays high until the result.
// result channel: done is high for exactly one cycle with vertex_index, added_new,
// overflow and unique_count; the receiver cannot hold it off, so results never wait.
// the unique-vertex store is one memory, one entry per row, walked oldest first
// through a four-stage compare pipeline (read, difference, square, sum and compare).
// the walk reads every stored entry when nothing matches (first_of_mesh empties the
// store first), ends at the first match and reads nothing from an empty store.
// one vertex is in flight at a time and the next request can be taken at the edge
// that ends the done cycle.
// new vertices are written at the end of the walk into the next free row.
// configuration: apb registers at 0x0 position_tolerance_sq, 0x4 normal_tolerance_sq,
// 0x8 texcoord_tolerance, to be written by the user only while busy is low; the block
// itself does not enforce this; pready is always high.
// reset: the store is empty and the tolerances read 66; memory contents are not cleared,
// only rows below the fill count are ever compared.
module vertex_weld_index_builder
    import vwib_pkg::*;
#(
    parameter int MAX_UNIQUE = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // vertex request
    input  logic                   start,
    output logic                   busy,
    input  logic                   first_of_mesh,
    input  logic signed [31:0]     pos_x,
    input  logic signed [31:0]     pos_y,
    input  logic signed [31:0]     pos_z,
    input  logic signed [31:0]     nrm_x,
    input  logic signed [31:0]     nrm_y,
    input  logic signed [31:0]     nrm_z,
    input  logic signed [31:0]     tex_u,
    input  logic signed [31:0]     tex_v,
    // result
    output logic                   done,
    output logic [INDEX_W-1:0]     vertex_index,
    output logic                   added_new,
    output logic                   overflow,
    output logic [COUNT_W-1:0]     unique_count,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int AW = $clog2(MAX_UNIQUE);
    localparam int CW = $clog2(MAX_UNIQUE + 1);
    localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int NC = 6;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_UNIQUE);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    // configuration registers
    logic [TOL_W-1:0]     pos_tol_reg;
    logic [TOL_W-1:0]     nrm_tol_reg;
    logic [TOL_W-1:0]     tex_tol_reg;
    logic [REG_IDX_W-1:0] reg_sel;
    logic                 cfg_wr;

    // control
    logic          state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          accept;
    logic          issuing;
    logic          pipe_empty;
    logic          found;
    logic          finish;

    // request payload
    vertex_t in_vtx_reg;

    // memory ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    vertex_t       rd_vtx;

    // compare pipeline
    logic          rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;

    coord_t           mem_c [NC];
    coord_t           ref_c [NC];
    logic [COORD_W:0] c_abs [NC];
    logic [COORD_W:0] u_abs;
    logic [COORD_W:0] v_abs;

    logic               d_vld_reg;
    logic [AW-1:0]      d_idx_reg;
    logic [SQ_IN_W-1:0] d_abs_reg [NC];
    logic [NC-1:0]      d_big_reg;
    logic               d_tex_ok_reg;

    logic          sq_vld_reg;
    logic [AW-1:0] sq_idx_reg;
    logic [SQ_W-1:0] sq_reg [NC];
    logic          sq_pos_big_reg;
    logic          sq_nrm_big_reg;
    logic          sq_tex_ok_reg;

    logic [SUM_W-1:0] pos_sum;
    logic [SUM_W-1:0] nrm_sum;
    logic [SUM_W-1:0] pos_lim;
    logic [SUM_W-1:0] nrm_lim;
    logic             cand_hit;

    logic          hit_vld_reg;
    logic          hit_reg;
    logic [AW-1:0] hit_idx_reg;

    // result
    logic [CW-1:0] res_idx;
    logic          res_added;
    logic          res_ovf;
    logic [XW-1:0] idx_ext;
    logic [XW-1:0] cnt_ext;
    logic          done_reg;
    logic [INDEX_W-1:0] vertex_index_reg;
    logic          added_new_reg;
    logic          overflow_reg;
    logic [COUNT_W-1:0] unique_count_reg;

    // apb register file
    assign reg_sel = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_tol_reg <= TOL_RESET;
            nrm_tol_reg <= TOL_RESET;
            tex_tol_reg <= TOL_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_POS_TOL: pos_tol_reg <= pwdata;
                REG_NRM_TOL: nrm_tol_reg <= pwdata;
                REG_TEX_TOL: tex_tol_reg <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_POS_TOL: prdata = pos_tol_reg;
            REG_NRM_TOL: prdata = nrm_tol_reg;
            REG_TEX_TOL: prdata = tex_tol_reg;
            default:     prdata = '0;
        endcase
    end

    // request handshake and walk control
    assign busy       = (state_reg == ST_SEARCH);
    assign accept     = start && !busy;
    assign issuing    = (state_reg == ST_SEARCH) && (ptr_reg < count_reg);
    assign pipe_empty = !issuing && !rd_vld_reg && !d_vld_reg && !sq_vld_reg && !hit_vld_reg;
    assign found      = hit_vld_reg && hit_reg;
    assign finish     = (state_reg == ST_SEARCH) && (found || pipe_empty);

    // fill-count clear on a first_of_mesh request and result selection at the end of the walk
    always_comb
    begin
        res_idx    = '0;
        res_added  = 1'b0;
        res_ovf    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[AW-1:0];
        count_next = count_reg;
        if (accept && first_of_mesh)
        begin
            count_next = '0;
        end
        else if (finish)
        begin
            if (found)
            begin
                res_idx = CW'(hit_idx_reg);
            end
            else if (count_reg < MAX_CNT)
            begin
                mem_we     = 1'b1;
                res_idx    = count_reg;
                res_added  = 1'b1;
                count_next = count_reg + 1'b1;
            end
            else
            begin
                res_ovf = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SEARCH;
                    ptr_next   = '0;
                end
            end
            ST_SEARCH:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
                else if (issuing)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end

    // latch the request vertex
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_vtx_reg <= {pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v};
        end
    end

    // unique-vertex store
    vwib_ram
    #(
        .WIDTH ($bits(vertex_t)),
        .DEPTH (MAX_UNIQUE)
    )
    u_store
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (in_vtx_reg),
        .re    (issuing),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rd_vtx)
    );

    // pipeline valid bits, flushed when the walk ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            d_vld_reg   <= 1'b0;
            sq_vld_reg  <= 1'b0;
            hit_vld_reg <= 1'b0;
        end
        else if (finish)
        begin
            rd_vld_reg  <= 1'b0;
            d_vld_reg   <= 1'b0;
            sq_vld_reg  <= 1'b0;
            hit_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= issuing;
            d_vld_reg   <= rd_vld_reg;
            sq_vld_reg  <= d_vld_reg;
            hit_vld_reg <= sq_vld_reg;
        end
    end

    // difference stage
    assign mem_c[0] = rd_vtx.pos_x;
    assign mem_c[1] = rd_vtx.pos_y;
    assign mem_c[2] = rd_vtx.pos_z;
    assign mem_c[3] = rd_vtx.nrm_x;
    assign mem_c[4] = rd_vtx.nrm_y;
    assign mem_c[5] = rd_vtx.nrm_z;
    assign ref_c[0] = in_vtx_reg.pos_x;
    assign ref_c[1] = in_vtx_reg.pos_y;
    assign ref_c[2] = in_vtx_reg.pos_z;
    assign ref_c[3] = in_vtx_reg.nrm_x;
    assign ref_c[4] = in_vtx_reg.nrm_y;
    assign ref_c[5] = in_vtx_reg.nrm_z;

    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            c_abs[i] = abs_diff(mem_c[i], ref_c[i]);
        end
    end

    assign u_abs = abs_diff(rd_vtx.tex_u, in_vtx_reg.tex_u);
    assign v_abs = abs_diff(rd_vtx.tex_v, in_vtx_reg.tex_v);

    always_ff @(posedge clk)
    begin
        d_idx_reg    <= rd_idx_reg;
        d_tex_ok_reg <= (u_abs < {1'b0, tex_tol_reg}) && (v_abs < {1'b0, tex_tol_reg});
        for (int i = 0; i < NC; i++)
        begin
            d_abs_reg[i] <= c_abs[i][SQ_IN_W-1:0];
            d_big_reg[i] <= |c_abs[i][COORD_W:SQ_IN_W];
        end
    end

    // read index, registered alongside the memory read data
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= ptr_reg[AW-1:0];
    end

    // square stage
    always_ff @(posedge clk)
    begin
        sq_idx_reg     <= d_idx_reg;
        sq_pos_big_reg <= |d_big_reg[2:0];
        sq_nrm_big_reg <= |d_big_reg[5:3];
        sq_tex_ok_reg  <= d_tex_ok_reg;
        for (int i = 0; i < NC; i++)
        begin
            sq_reg[i] <= d_abs_reg[i] * d_abs_reg[i];
        end
    end

    // sum and compare stage
    assign pos_sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    assign nrm_sum = SUM_W'(sq_reg[3]) + SUM_W'(sq_reg[4]) + SUM_W'(sq_reg[5]);
    assign pos_lim = SUM_W'({pos_tol_reg, {FRAC_W{1'b0}}});
    assign nrm_lim = SUM_W'({nrm_tol_reg, {FRAC_W{1'b0}}});
    assign cand_hit = !sq_pos_big_reg && !sq_nrm_big_reg && sq_tex_ok_reg &&
                      (pos_sum < pos_lim) && (nrm_sum < nrm_lim);

    always_ff @(posedge clk)
    begin
        hit_reg     <= cand_hit;
        hit_idx_reg <= sq_idx_reg;
    end

    // result register, shown for one cycle
    assign idx_ext = XW'(res_idx);
    assign cnt_ext = XW'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            vertex_index_reg <= idx_ext[INDEX_W-1:0];
            added_new_reg    <= res_added;
            overflow_reg     <= res_ovf;
            unique_count_reg <= cnt_ext[COUNT_W-1:0];
        end
    end

    assign done         = done_reg;
    assign vertex_index = vertex_index_reg;
    assign added_new    = added_new_reg;
    assign overflow     = overflow_reg;
    assign unique_count = unique_count_reg;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result shown while a walk is still running");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(added_new_reg && overflow_reg))
        else $error("vertex both added and overflowed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && overflow_reg) |-> (count_reg == MAX_CNT))
        else $error("overflow reported with room left in the store");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("fill count beyond store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        hit_vld_reg |-> (state_reg == ST_SEARCH))
        else $error("compare result valid outside a walk");

endmodule
